// ===== sv/dht_pkg.sv =====
// Shared types, field widths and codes for the double hashing key table.
package dht_pkg;

    // Field widths
    localparam int KEY_W = 31;
    localparam int CNT_W = 15;
    localparam int MP_W  = 15;
    localparam int MS_W  = 14;

    // Default storage depth and modulus reset values
    localparam int unsigned DEFAULT_TABLE_DEPTH = 16384;
    localparam logic [MP_W-1:0] MP_RESET = 15'd7;
    localparam logic [MS_W-1:0] MS_RESET = 14'd5;

    // Remainder unit: dividend padded to whole digits, four bits a cycle
    localparam int DIG_BITS  = 4;
    localparam int DVD_W     = 32;
    localparam int DIV_STEPS = DVD_W / DIG_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Configuration register indexes
    localparam logic CFG_PRIMARY   = 1'b0;
    localparam logic CFG_SECONDARY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_M2,
        ST_MOD_M,
        ST_MOD_STEP,
        ST_PROBE,
        ST_CHECK,
        ST_OUT
    } state_t;

    // Request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [MP_W-1:0]   divisor;
    } div_req_t;

    // Response of the remainder unit
    typedef struct packed {
        logic              done;
        logic [MP_W-1:0]   remainder;
    } div_rsp_t;

endpackage

// ===== sv/double_hash_table_core.sv =====
// Double hashing open-addressed key table: top level with probe sequencer.
// Operation: three remainder passes for set-up (key mod m2, key mod m, step mod m), then
//   per probe a RAM read and a compare, then the result is registered.
// One operation at a time: a new command is taken only once the last result is registered;
//   each probe is one read of the single-port slot RAM.
// Reset: async active low; a clearing pass then writes zero to every slot, one a cycle,
//   with the input held off; configuration writes are taken as ever.
module double_hash_table_core #(
    parameter int unsigned TABLE_DEPTH = dht_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Command channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [dht_pkg::KEY_W-1:0]  key,
    // Result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dht_pkg::CNT_W-1:0]  probes,
    output logic                       success,
    // Configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [dht_pkg::MP_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > 32767) ? 32767 : TABLE_DEPTH;

    // (a + b) mod m for a, b below m
    function automatic logic [dht_pkg::MP_W-1:0] mod_add(
        input logic [dht_pkg::MP_W-1:0] a,
        input logic [dht_pkg::MP_W-1:0] b,
        input logic [dht_pkg::MP_W-1:0] m
    );
        logic [dht_pkg::MP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[dht_pkg::MP_W-1:0];
    endfunction

    dht_pkg::state_t state_reg, state_next;

    logic [dht_pkg::MP_W-1:0]   mp_reg;
    logic [dht_pkg::MS_W-1:0]   ms_reg;
    logic [dht_pkg::MP_W-1:0]   m_eff;
    logic [dht_pkg::MS_W-1:0]   ms_eff;

    logic [ADDR_W-1:0]          clr_addr_reg;
    logic                       clr_last;

    logic                       cmd_reg;
    logic [dht_pkg::KEY_W-1:0]  key_reg;
    logic [dht_pkg::MP_W-1:0]   step_reg;
    logic [dht_pkg::MP_W-1:0]   base_reg;
    logic [dht_pkg::MP_W-1:0]   stepm_reg;
    logic [dht_pkg::MP_W-1:0]   slot_reg;
    logic [dht_pkg::CNT_W-1:0]  i_reg;

    logic [dht_pkg::CNT_W-1:0]  res_count_reg;
    logic                       res_ok_reg;
    logic                       out_valid_reg;
    logic [dht_pkg::CNT_W-1:0]  probes_reg;
    logic                       success_reg;

    dht_pkg::div_req_t          div_req;
    dht_pkg::div_rsp_t          div_rsp;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic [dht_pkg::KEY_W-1:0]  ram_wdata;
    logic [dht_pkg::KEY_W-1:0]  ram_rdata;

    logic                       held_empty;
    logic                       held_match;
    logic                       hit;
    logic                       last;
    logic                       out_free;

    // Effective moduli
    always_comb
    begin
        if (mp_reg == '0)
        begin
            m_eff = dht_pkg::MP_W'(1);
        end
        else if (mp_reg > dht_pkg::MP_W'(DEPTH_CAP))
        begin
            m_eff = dht_pkg::MP_W'(DEPTH_CAP);
        end
        else
        begin
            m_eff = mp_reg;
        end
        ms_eff = (ms_reg == '0) ? dht_pkg::MS_W'(1) : ms_reg;
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg <= dht_pkg::MP_RESET;
            ms_reg <= dht_pkg::MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dht_pkg::CFG_PRIMARY:   mp_reg <= cfg_data;
                dht_pkg::CFG_SECONDARY: ms_reg <= cfg_data[dht_pkg::MS_W-1:0];
            endcase
        end
    end

    // Probe outcome on the RAM read data
    assign held_empty = (ram_rdata == '0);
    assign held_match = (ram_rdata == key_reg);
    assign hit        = (cmd_reg == dht_pkg::CMD_INSERT) ? held_empty
                                                         : (held_match || held_empty);
    assign last       = (i_reg == m_eff);
    assign clr_last   = (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign out_free   = !out_valid_reg || out_ready;

    // Next state, remainder unit requests, RAM control
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = dht_pkg::DVD_W'(key_reg);
        div_req.divisor  = m_eff;
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = ADDR_W'(slot_reg);
        ram_wdata        = key_reg;
        unique case (state_reg)
            dht_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
                if (clr_last)
                begin
                    state_next = dht_pkg::ST_IDLE;
                end
            end
            dht_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dht_pkg::DVD_W'(key);
                    div_req.divisor  = {1'b0, ms_eff};
                    state_next       = dht_pkg::ST_MOD_M2;
                end
            end
            dht_pkg::ST_MOD_M2:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = dht_pkg::ST_MOD_M;
                end
            end
            dht_pkg::ST_MOD_M:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dht_pkg::DVD_W'(step_reg);
                    state_next       = dht_pkg::ST_MOD_STEP;
                end
            end
            dht_pkg::ST_MOD_STEP:
            begin
                if (div_rsp.done)
                begin
                    state_next = dht_pkg::ST_PROBE;
                end
            end
            dht_pkg::ST_PROBE:
            begin
                state_next = dht_pkg::ST_CHECK;
            end
            dht_pkg::ST_CHECK:
            begin
                // Insert claims the first empty slot it reads
                ram_we = (cmd_reg == dht_pkg::CMD_INSERT) && held_empty;
                state_next = (hit || last) ? dht_pkg::ST_OUT : dht_pkg::ST_PROBE;
            end
            dht_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = dht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dht_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dht_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dht_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Operation datapath; a probe's write completes before the next read is issued
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dht_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg <= cmd;
                    key_reg <= key;
                end
            end
            dht_pkg::ST_MOD_M2:
            begin
                if (div_rsp.done)
                begin
                    step_reg <= div_rsp.remainder + 1'b1;
                end
            end
            dht_pkg::ST_MOD_M:
            begin
                if (div_rsp.done)
                begin
                    base_reg <= div_rsp.remainder;
                end
            end
            dht_pkg::ST_MOD_STEP:
            begin
                if (div_rsp.done)
                begin
                    stepm_reg <= div_rsp.remainder;
                    slot_reg  <= mod_add(base_reg, div_rsp.remainder, m_eff);
                    i_reg     <= dht_pkg::CNT_W'(1);
                end
            end
            dht_pkg::ST_CHECK:
            begin
                if (hit)
                begin
                    res_count_reg <= i_reg;
                    res_ok_reg    <= (cmd_reg == dht_pkg::CMD_INSERT) || held_match;
                end
                else if (last)
                begin
                    res_count_reg <= (cmd_reg == dht_pkg::CMD_INSERT) ? m_eff
                                                                      : m_eff + 1'b1;
                    res_ok_reg    <= 1'b0;
                end
                else
                begin
                    i_reg    <= i_reg + 1'b1;
                    slot_reg <= mod_add(slot_reg, stepm_reg, m_eff);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == dht_pkg::ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dht_pkg::ST_OUT && out_free)
        begin
            probes_reg  <= res_count_reg;
            success_reg <= res_ok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign probes    = probes_reg;
    assign success   = success_reg;

    // Remainder unit
    dht_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Slot store
    dht_ram #(
        .WIDTH (dht_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Outside the clear sweep, only an insert that read an empty slot writes
    a_write_only_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != dht_pkg::ST_CLEAR) |->
            (cmd_reg == dht_pkg::CMD_INSERT && ram_rdata == '0))
        else $error("slot write outside an insert into an empty slot");

    // Probed slot stays inside the table in use
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dht_pkg::ST_PROBE || state_reg == dht_pkg::ST_CHECK) |->
            (slot_reg < m_eff && i_reg != '0 && i_reg <= m_eff))
        else $error("probe slot or count out of range");

    // The remainder unit reports only while a set-up pass is waiting for it
    a_div_done_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == dht_pkg::ST_MOD_M2 || state_reg == dht_pkg::ST_MOD_M
                          || state_reg == dht_pkg::ST_MOD_STEP))
        else $error("remainder result outside set-up");

endmodule

// ===== sv/dht_ram.sv =====
// Generic single-port RAM with registered read data.
module dht_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read, read-before-write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dht_mod.sv =====
// Iterative remainder unit: 32-bit dividend modulo a nonzero 15-bit divisor.
module dht_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  dht_pkg::div_req_t req,
    output dht_pkg::div_rsp_t rsp
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [dht_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [dht_pkg::DVD_W-1:0]          dvd_reg;
    logic [dht_pkg::MP_W-1:0]           div_reg;
    logic [dht_pkg::MP_W-1:0]           rem_reg;
    logic [dht_pkg::MP_W-1:0]           rem_next;

    // One digit of restoring division: four shift-compare-subtract steps
    always_comb
    begin
        logic [dht_pkg::MP_W:0] t;
        rem_next = rem_reg;
        for (int j = 0; j < dht_pkg::DIG_BITS; j++)
        begin
            t = {rem_next, dvd_reg[dht_pkg::DVD_W-1-j]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            rem_next = t[dht_pkg::MP_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == dht_pkg::DIV_CNT_W'(dht_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << dht_pkg::DIG_BITS;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the double hashing key table core.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned TABLE_DEPTH = dht_pkg::DEFAULT_TABLE_DEPTH;
    // Slowest run: clearing pass plus every op probing its whole table under full stalls
    localparam int CYCLE_LIMIT = 2_500_000;

    typedef struct packed {
        logic                      cmd;
        logic [dht_pkg::KEY_W-1:0] key;
    } table_op_t;

    typedef struct packed {
        logic [dht_pkg::CNT_W-1:0] count;
        logic                      hit;
    } probe_result_t;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic                       cmd         = dht_pkg::CMD_INSERT;
    logic [dht_pkg::KEY_W-1:0]  key         = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic [dht_pkg::CNT_W-1:0]  probes;
    logic                       success;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index   = dht_pkg::CFG_PRIMARY;
    logic [dht_pkg::MP_W-1:0]   cfg_data    = '0;

    // Mirror of the table contents and moduli
    logic [dht_pkg::KEY_W-1:0]  slot_mirror [TABLE_DEPTH];
    logic [dht_pkg::MP_W-1:0]   mirror_primary   = dht_pkg::MP_RESET;
    logic [dht_pkg::MS_W-1:0]   mirror_secondary = dht_pkg::MS_RESET;

    table_op_t                  pending_ops [$];
    probe_result_t              expected_q  [$];
    logic [dht_pkg::KEY_W-1:0]  key_pool    [$];

    int                         n_queued    = 0;
    int                         n_checked   = 0;
    int                         errors      = 0;
    int                         cycle_count = 0;
    int                         send_gap    = 0;
    int                         recv_gap    = 0;
    bit                         quiet       = 1'b0;
    logic                       in_accepted = 1'b0;
    table_op_t                  next_op;
    table_op_t                  seen_op;
    probe_result_t              want;

    double_hash_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .probes      (probes),
        .success     (success),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Probe the mirrored table the way the block does; updates the mirror on insert
    function automatic probe_result_t probe_table(input table_op_t op);
        longint unsigned m;
        longint unsigned m2;
        longint unsigned base;
        longint unsigned stride;
        longint unsigned slot;
        longint unsigned i;
        logic [dht_pkg::KEY_W-1:0] held;
        bit               done;
        probe_result_t    res;
        m = (mirror_primary == 0) ? 1 : mirror_primary;
        if (m > TABLE_DEPTH)
            m = TABLE_DEPTH;
        m2 = (mirror_secondary == 0) ? 1 : mirror_secondary;
        base = op.key % m;
        stride = 1 + op.key % m2;
        done = 1'b0;
        res.hit = 1'b0;
        res.count = (op.cmd == dht_pkg::CMD_INSERT) ? dht_pkg::CNT_W'(m)
                                                    : dht_pkg::CNT_W'(m + 1);
        for (i = 1; i <= m && !done; i++)
        begin
            slot = (base + (i * stride) % m) % m;
            held = slot_mirror[slot];
            if (op.cmd == dht_pkg::CMD_INSERT)
            begin
                if (held == 0)
                begin
                    slot_mirror[slot] = op.key;
                    res.count = dht_pkg::CNT_W'(i);
                    res.hit = 1'b1;
                    done = 1'b1;
                end
            end
            else if (held == op.key || held == 0)
            begin
                res.count = dht_pkg::CNT_W'(i);
                res.hit = (held == op.key);
                done = 1'b1;
            end
        end
        return res;
    endfunction

    // Key mix: full-width random, small, near the top, shifted patterns
    function automatic logic [dht_pkg::KEY_W-1:0] rand_key();
        logic [dht_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 5))
            0, 1, 2: k = dht_pkg::KEY_W'($urandom);
            3:       k = dht_pkg::KEY_W'($urandom_range(1, 4096));
            4:       k = {dht_pkg::KEY_W{1'b1}} - dht_pkg::KEY_W'($urandom_range(0, 15));
            default: k = dht_pkg::KEY_W'($urandom_range(1, 255)) << $urandom_range(0, 23);
        endcase
        return k;
    endfunction

    task automatic push_op(input logic op_cmd, input logic [dht_pkg::KEY_W-1:0] op_key);
        table_op_t op;
        op.cmd = op_cmd;
        op.key = op_key;
        pending_ops.insert(pending_ops.size(), op);
        n_queued++;
        if (op_cmd == dht_pkg::CMD_INSERT && op_key != 0)
        begin
            key_pool.insert(key_pool.size(), op_key);
            if (key_pool.size() > 64)
                void'(key_pool.pop_front());
        end
    endtask

    // Hold the sender until every queued op has its result back
    task automatic drain();
        while (n_checked != n_queued)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [dht_pkg::MP_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == dht_pkg::CFG_PRIMARY)
            mirror_primary = val;
        else
            mirror_secondary = val[dht_pkg::MS_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_moduli(input logic [dht_pkg::MP_W-1:0] prim,
                              input logic [dht_pkg::MP_W-1:0] sec);
        drain();
        write_reg(dht_pkg::CFG_PRIMARY, prim);
        write_reg(dht_pkg::CFG_SECONDARY, sec);
    endtask

    // Mostly insert-then-look-up traffic, with misses, zero keys and noise
    task automatic run_phase(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                push_op(dht_pkg::CMD_INSERT, rand_key());
            else if (r < 70 && key_pool.size() > 0)
                push_op(dht_pkg::CMD_SEARCH,
                        key_pool[$urandom_range(0, key_pool.size() - 1)]);
            else if (r < 82)
                push_op(dht_pkg::CMD_SEARCH, rand_key());
            else if (r < 88)
                push_op(logic'($urandom_range(0, 1)), '0);
            else if (r < 94 && key_pool.size() > 0)
                push_op(dht_pkg::CMD_INSERT,
                        key_pool[$urandom_range(0, key_pool.size() - 1)]);
            else
                push_op(logic'($urandom_range(0, 1)), dht_pkg::KEY_W'($urandom));
        end
    endtask

    // Command driver: a new op only once the previous transfer has happened
    always @(negedge clk)
    begin
        if (!in_valid || in_accepted)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                next_op = pending_ops.pop_front();
                in_valid <= 1'b1;
                cmd      <= next_op.cmd;
                key      <= next_op.key;
                if (!quiet && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side stalls in bursts
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            recv_gap = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: predict on each command transfer, check each result transfer
    always @(posedge clk)
    begin
        in_accepted <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen_op.cmd = cmd;
                seen_op.key = key;
                expected_q.insert(expected_q.size(), probe_table(seen_op));
            end
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual count %0d success %0b",
                             $time, probes, success);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (probes !== want.count)
                    begin
                        errors++;
                        $display("%0t: probes mismatch, expected %0d, actual %0d",
                                 $time, want.count, probes);
                    end
                    if (success !== want.hit)
                    begin
                        errors++;
                        $display("%0t: success mismatch, expected %0b, actual %0b",
                                 $time, want.hit, success);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        foreach (slot_mirror[i])
            slot_mirror[i] = '0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset moduli (7, 5)
        push_op(dht_pkg::CMD_SEARCH, '0);                      // zero matches an empty slot
        push_op(dht_pkg::CMD_SEARCH, {dht_pkg::KEY_W{1'b1}});  // miss on empty table
        push_op(dht_pkg::CMD_INSERT, {dht_pkg::KEY_W{1'b1}});
        push_op(dht_pkg::CMD_INSERT, 31'd1);
        push_op(dht_pkg::CMD_INSERT, '0);                      // zero leaves the slot empty
        push_op(dht_pkg::CMD_INSERT, 31'd1);                   // duplicate goes elsewhere
        push_op(dht_pkg::CMD_SEARCH, 31'd1);
        push_op(dht_pkg::CMD_SEARCH, {dht_pkg::KEY_W{1'b1}});
        push_op(dht_pkg::CMD_SEARCH, '0);
        for (int k = 2; k <= 6; k++)
            push_op(dht_pkg::CMD_INSERT, dht_pkg::KEY_W'(k));  // fills all seven slots
        push_op(dht_pkg::CMD_INSERT, 31'd9);                   // table full
        push_op(dht_pkg::CMD_SEARCH, 31'd100);                 // search runs out of probes
        push_op(dht_pkg::CMD_SEARCH, '0);                      // no empty slot left
        push_op(dht_pkg::CMD_INSERT, '0);                      // full as well
        push_op(dht_pkg::CMD_SEARCH, 31'd6);

        // Random part over a range of moduli
        set_moduli(15'd13, 15'd11);
        run_phase(60);
        set_moduli(15'd61, 15'd59);
        run_phase(80);
        set_moduli(15'd0, 15'd0);             // both read as one
        run_phase(10);
        set_moduli(15'd16384, 15'd16383);     // upper extremes
        run_phase(10);
        set_moduli(15'h7FFF, 15'h4003);       // primary clamps, secondary keeps 14 bits
        run_phase(8);
        set_moduli(15'd3, 15'd2);             // lower extremes, fills quickly
        run_phase(30);
        set_moduli(15'd31, 15'd37);           // secondary above primary
        run_phase(40);
        set_moduli(15'd127, 15'd113);
        run_phase(120);

        // Closing stretch without idling on either side
        set_moduli(15'd97, 15'd89);
        quiet = 1'b1;
        run_phase(60);

        drain();
        repeat (100)
            @(negedge clk);
        if (expected_q.size() != 0)
        begin
            errors++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_q.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dht_pkg.sv
sv/dht_ram.sv
sv/dht_mod.sv
sv/double_hash_table_core.sv
dv/tb.sv
